@@ hdl/rgba8_box_downsample_2x2_core_assert.svh @@
// Assertion macros for the 2x2 box downsampler.
// RBDS2_ASSERT checks a property on every clock edge outside reset.
// RBDS2_ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef RGBA8_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH
`define RGBA8_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RBDS2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RBDS2_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define RBDS2_ASSERT(label, prop, msg)
`define RBDS2_ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ hdl/rbds2_pkg.sv @@
`default_nettype none

package rbds2_pkg;

    localparam int MAX_HALF_WIDTH    = 2048;
    localparam int HALF_HEIGHT_LIMIT = 2048;
    localparam int ADDR_W            = $clog2(MAX_HALF_WIDTH);
    localparam int HALF_W            = 12;
    localparam int CNT_W             = 12;
    localparam int LAST_W            = HALF_W + 1;
    localparam int PIX_W             = 32;
    localparam int BYTE_W            = 8;
    localparam int LANES             = 4;
    localparam int LANE_W            = BYTE_W + 1;
    localparam int SUM_W             = LANES * LANE_W;
    localparam int CFG_INDEX_W       = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_WIDTH  = 1'b0,
        REG_HALF_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SUM_W-1:0] pair_sum_t;

    // Per-channel sums of two pixels, four 9-bit lanes.
    function automatic pair_sum_t pair_sum(input logic [PIX_W-1:0] a,
                                           input logic [PIX_W-1:0] b);
        pair_sum_t packed_sum;
        packed_sum = '0;
        for (int k = 0; k < LANES; k++) begin
            packed_sum[k*LANE_W +: LANE_W] = {1'b0, a[k*BYTE_W +: BYTE_W]}
                                           + {1'b0, b[k*BYTE_W +: BYTE_W]};
        end
        return packed_sum;
    endfunction

    // Add two rows of pair sums and take the floor of the mean per channel.
    function automatic logic [PIX_W-1:0] block_mean(input pair_sum_t below,
                                                    input pair_sum_t above);
        logic [PIX_W-1:0]  res;
        logic [LANE_W:0]   s;
        res = '0;
        for (int k = 0; k < LANES; k++) begin
            s = {1'b0, below[k*LANE_W +: LANE_W]} + {1'b0, above[k*LANE_W +: LANE_W]};
            res[k*BYTE_W +: BYTE_W] = s[LANE_W:2];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rgba8_box_downsample_2x2_core.sv @@
// 2x2 box downsampler for RGBA8 pixel streams.
// Input: s_valid/s_ready carry one 32-bit pixel per transaction, raster order,
// image of 2*half_width by 2*half_height pixels (byte 0 in the low bits).
// Output: m_valid/m_ready carry one pixel per 2x2 block, each channel the
// floor of the mean of the four source bytes; m_frame_end marks the last
// output pixel of the frame.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index
// (0 half_width, 1 half_height); any write restarts the frame. Write only
// while the block is idle.
// Throughput: one pixel per clock unless stalled. Even-row pair sums go
// into a 2048-entry line memory with one port; odd rows read it back, so
// each pixel costs one memory access at most and the port sustains one
// pixel per clock. Accepting the right pixel of an odd-row pair loads the
// pair sum and the memory read into the pending block registers; the block
// mean is then registered in the output register that drives m_valid.
// Reset: counters, held pixel and valid flags clear; sizes go to 1. The line
// memory is not cleared and needs no clearing pass.
// Stall: with m_ready low the output register and one pending block hold,
// and s_ready drops only when both are full.
`default_nettype none

module rgba8_box_downsample_2x2_core
    import rbds2_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [HALF_W-1:0]        cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [PIX_W-1:0]         s_pixel_in,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [PIX_W-1:0]              m_pixel_out,
    output logic                          m_frame_end
);

    logic [SUM_W-1:0]  line_mem [MAX_HALF_WIDTH];

    logic [HALF_W-1:0] half_width_reg,  half_width_next;
    logic [HALF_W-1:0] half_height_reg, half_height_next;
    logic [CNT_W-1:0]  col_cnt_reg,     col_cnt_next;
    logic [CNT_W-1:0]  row_cnt_reg,     row_cnt_next;
    logic [PIX_W-1:0]  left_pix_reg,    left_pix_next;

    logic              blk_valid_reg,   blk_valid_next;
    pair_sum_t         blk_sum_reg;
    logic              blk_end_reg;
    pair_sum_t         above_reg;

    logic              out_valid_reg,   out_valid_next;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_end_reg;

    logic [HALF_W-1:0] hw_eff, hh_eff;
    logic [LAST_W-1:0] last_col, last_row;
    logic              accept, blk_advance, out_free;
    logic              mem_wr, mem_rd, is_last_col, is_last_row;
    logic [ADDR_W-1:0] mem_addr;
    pair_sum_t         cur_sum;

    always_comb begin
        hw_eff = half_width_reg;
        if (half_width_reg == '0) begin
            hw_eff = HALF_W'(1);
        end else if (half_width_reg > HALF_W'(MAX_HALF_WIDTH)) begin
            hw_eff = HALF_W'(MAX_HALF_WIDTH);
        end
        hh_eff = half_height_reg;
        if (half_height_reg == '0) begin
            hh_eff = HALF_W'(1);
        end else if (half_height_reg > HALF_W'(HALF_HEIGHT_LIMIT)) begin
            hh_eff = HALF_W'(HALF_HEIGHT_LIMIT);
        end
    end

    assign last_col    = {hw_eff, 1'b0} - LAST_W'(1);
    assign last_row    = {hh_eff, 1'b0} - LAST_W'(1);
    assign is_last_col = {1'b0, col_cnt_reg} >= last_col;
    assign is_last_row = {1'b0, row_cnt_reg} >= last_row;

    assign out_free    = !out_valid_reg || m_ready;
    assign blk_advance = blk_valid_reg && out_free;
    assign s_ready     = !blk_valid_reg || out_free;
    assign accept      = s_valid && s_ready;

    assign cur_sum  = pair_sum(left_pix_reg, s_pixel_in);
    assign mem_addr = col_cnt_reg[ADDR_W:1];
    assign mem_wr   = accept && col_cnt_reg[0] && !row_cnt_reg[0];
    assign mem_rd   = accept && col_cnt_reg[0] && row_cnt_reg[0];

    always_comb begin
        half_width_next  = half_width_reg;
        half_height_next = half_height_reg;
        col_cnt_next     = col_cnt_reg;
        row_cnt_next     = row_cnt_reg;
        left_pix_next    = left_pix_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_HALF_WIDTH:  half_width_next  = cfg_wr_data;
                REG_HALF_HEIGHT: half_height_next = cfg_wr_data;
                default:         half_width_next  = half_width_reg;
            endcase
            // restart the frame, keep the line memory
            col_cnt_next  = '0;
            row_cnt_next  = '0;
            left_pix_next = '0;
        end else if (accept) begin
            if (!col_cnt_reg[0]) begin
                left_pix_next = s_pixel_in;
            end
            if (is_last_col) begin
                col_cnt_next = '0;
                row_cnt_next = is_last_row ? '0 : row_cnt_reg + CNT_W'(1);
            end else begin
                col_cnt_next = col_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        blk_valid_next = blk_valid_reg;
        if (mem_rd) begin
            blk_valid_next = 1'b1;
        end else if (blk_advance) begin
            blk_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (blk_advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= HALF_W'(1);
            half_height_reg <= HALF_W'(1);
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            left_pix_reg    <= '0;
            blk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            half_width_reg  <= half_width_next;
            half_height_reg <= half_height_next;
            col_cnt_reg     <= col_cnt_next;
            row_cnt_reg     <= row_cnt_next;
            left_pix_reg    <= left_pix_next;
            blk_valid_reg   <= blk_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Pending block payload: the odd-row pair sum and the row above from memory.
    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            blk_sum_reg <= cur_sum;
            blk_end_reg <= is_last_col && is_last_row;
        end
        if (blk_advance) begin
            out_pix_reg <= block_mean(blk_sum_reg, above_reg);
            out_end_reg <= blk_end_reg;
        end
    end

    // Even and odd rows never access the memory in the same cycle.
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            line_mem[mem_addr] <= cur_sum;
        end
        if (mem_rd) begin
            above_reg <= line_mem[mem_addr];
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_pixel_out = out_pix_reg;
    assign m_frame_end = out_end_reg;

`include "rgba8_box_downsample_2x2_core_assert.svh"

    `RBDS2_ASSERT(a_read_fills_block, mem_rd |=> blk_valid_reg, "memory read lost its block")
    `RBDS2_ASSERT(a_stall_only_full, !s_ready |-> (blk_valid_reg && out_valid_reg), "input stalled with room free")
    `RBDS2_ASSERT(a_end_wraps, (blk_valid_reg && blk_end_reg) |-> (col_cnt_reg == '0 && row_cnt_reg == '0), "frame end without counter wrap")
    `RBDS2_ASSERT_NEVER(a_col_bound, {1'b0, col_cnt_reg} > last_col, "column count past row end")

endmodule

`default_nettype wire
